[src/frm_pkg.sv]
// Shared types, constants and codes for the frame allocator with translation.
package frm_pkg;

    localparam int MAX_FRAMES_DEF = 64;
    localparam int ID_WIDTH_DEF   = 8;

    localparam int AMT_W     = 32;
    localparam int MB_W      = 13;
    localparam int FIU_W     = 7;
    localparam int FRAME_W   = 6;
    localparam int ID_PORT_W = 8;
    localparam int PB_W      = 23;
    localparam int CFG_IDX_W = 1;

    localparam logic [PB_W-1:0]  PAGE_UNIT    = PB_W'(1000);
    localparam logic [MB_W-1:0]  MB_RESET     = MB_W'(1);
    localparam logic [FIU_W-1:0] FRAMES_RESET = FIU_W'(64);

    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES    = 1'b1;

    typedef enum logic [1:0] {
        OP_NEW  = 2'd0,
        OP_REF  = 2'd1,
        OP_END  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOFREE  = 2'd1,
        STAT_ACTIVE  = 2'd2,
        STAT_VIOL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_ALLOC,
        S_OUT
    } state_t;

    typedef struct packed {
        logic              done;
        logic [AMT_W-1:0]  quot;
        logic [PB_W-1:0]   rem;
    } div_res_t;

endpackage

[src/frm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module frm_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/frm_div.sv]
// Restoring divider, one quotient bit per cycle, for address over page bytes.
module frm_div
    import frm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [AMT_W-1:0] dividend,
    input  logic [PB_W-1:0]  divisor,
    output div_res_t         res
);

    localparam int STEP_W = $clog2(AMT_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [AMT_W-1:0]  quot_reg, quot_next;
    logic [PB_W-1:0]   rem_reg, rem_next;
    logic [PB_W-1:0]   dvs_reg, dvs_next;
    logic [PB_W:0]     trial;
    logic [PB_W:0]     diff;
    logic              ge;

    always_comb begin
        trial = {rem_reg, quot_reg[AMT_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[PB_W-1:0] : trial[PB_W-1:0];
            quot_next = {quot_reg[AMT_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(AMT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    always_comb begin
        res.done = done_reg;
        res.quot = quot_reg;
        res.rem  = rem_reg;
    end

endmodule

[src/frame_allocator_with_translation_unit.sv]
// Top level: frame owner table sequencer with shared divider and owner RAM.
// Sequence: new and ref run the 32-step divider, then read one owner entry per cycle through
//   the RAM read port over L = min(frames_in_use, MAX_FRAMES) entries; a granted new then marks
//   quot + 1 free entries with its id in an allocation pass; end scans and frees its own entries.
// Flow: a word is taken only once the last has left the FSM, even while its result waits on m_.
// Reset: a clearing pass marks every frame free; no word is taken meanwhile.
module frame_allocator_with_translation_unit
    import frm_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int ID_WIDTH   = ID_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MB_W-1:0]      cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_operation,
    input  logic [ID_PORT_W-1:0] s_process_id,
    input  logic [AMT_W-1:0]     s_amount,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [FRAME_W-1:0]   m_frame,
    output logic [AMT_W-1:0]     m_offset
);

    localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int EW = ID_WIDTH + 1;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [ID_WIDTH-1:0] id_reg, id_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       idx_d_reg, idx_d_next;
    logic [CW-1:0]       nfree_reg, nfree_next;
    logic                owned_reg, owned_next;
    logic [CW-1:0]       seen_reg, seen_next;
    logic                found_reg, found_next;
    logic [AW-1:0]       fidx_reg, fidx_next;
    logic [CW-1:0]       need_reg, need_next;
    status_t             res_status_reg, res_status_next;
    logic [FRAME_W-1:0]  res_frame_reg, res_frame_next;
    logic [AMT_W-1:0]    res_offset_reg, res_offset_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [FRAME_W-1:0]  out_frame_reg, out_frame_next;
    logic [AMT_W-1:0]    out_offset_reg, out_offset_next;
    logic [PB_W-1:0]     pb_reg, pb_next;
    logic [FIU_W-1:0]    fiu_reg, fiu_next;

    logic                accept;
    op_t                 s_op;
    logic [CW-1:0]       lim;
    logic                issue;
    logic                scan_end;
    logic                out_free;
    logic                ent_valid;
    logic [ID_WIDTH-1:0] ent_id;
    logic                ent_match;
    logic [MB_W-1:0]     mb_eff;

    logic                div_start;
    div_res_t            div_res;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [EW-1:0]       ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [EW-1:0]       ram_rdata;

    frm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_amount),
        .divisor  (pb_reg),
        .res      (div_res)
    );

    frm_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_FRAMES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        s_op      = op_t'(s_operation);
        accept    = s_valid && s_ready;
        ent_valid = ram_rdata[ID_WIDTH];
        ent_id    = ram_rdata[ID_WIDTH-1:0];
        ent_match = ent_valid && (ent_id == id_reg);
        out_free  = !out_valid_reg || m_ready;
        if (13'(fiu_reg) > 13'(MAX_FRAMES)) begin
            lim = CW'(MAX_FRAMES);
        end else begin
            lim = CW'(fiu_reg);
        end
        if (state_reg == S_ALLOC) begin
            issue = (cnt_reg < lim) && (need_reg != '0);
        end else begin
            issue = (state_reg == S_SCAN) && (cnt_reg < lim);
        end
        scan_end = !issue && !pend_reg;
    end

    // configuration registers
    always_comb begin
        pb_next  = pb_reg;
        fiu_next = fiu_reg;
        mb_eff   = (cfg_wdata == '0) ? MB_RESET : cfg_wdata;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_PAGE_SIZE: pb_next  = PB_W'(PB_W'(mb_eff) * PAGE_UNIT);
                REG_FRAMES:    fiu_next = cfg_wdata[FIU_W-1:0];
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (cnt_reg == CW'(MAX_FRAMES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (s_op) inside
                        OP_NEW, OP_REF: state_next = S_DIV;
                        OP_END:         state_next = S_SCAN;
                        default:        state_next = S_OUT;
                    endcase
                end
            end
            S_DIV: begin
                if (div_res.done) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    if (op_reg == OP_NEW && !owned_reg
                        && div_res.quot < AMT_W'(nfree_reg)) begin
                        state_next = S_ALLOC;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_ALLOC: begin
                if (need_reg == '0) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = idx_d_reg;
        ram_wdata = '0;
        ram_raddr = cnt_reg[AW-1:0];
        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
            end
            S_IDLE: begin
                s_ready   = 1'b1;
                div_start = s_valid && (s_op == OP_NEW || s_op == OP_REF);
            end
            S_SCAN: begin
                ram_we = pend_reg && (op_reg == OP_END) && ent_match;
            end
            S_ALLOC: begin
                ram_we    = pend_reg && !ent_valid && (need_reg != '0);
                ram_wdata = {1'b1, id_reg};
            end
            default: begin
            end
        endcase
    end

    // datapath
    always_comb begin
        op_next         = op_reg;
        id_next         = id_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        idx_d_next      = idx_d_reg;
        nfree_next      = nfree_reg;
        owned_next      = owned_reg;
        seen_next       = seen_reg;
        found_next      = found_reg;
        fidx_next       = fidx_reg;
        need_next       = need_reg;
        res_status_next = res_status_reg;
        res_frame_next  = res_frame_reg;
        res_offset_next = res_offset_reg;
        out_status_next = out_status_reg;
        out_frame_next  = out_frame_reg;
        out_offset_next = out_offset_reg;
        out_valid_next  = out_valid_reg && !m_ready;

        case (state_reg)
            S_CLEAR: begin
                cnt_next = cnt_reg + 1'b1;
            end
            S_IDLE: begin
                if (accept) begin
                    op_next         = s_op;
                    id_next         = ID_WIDTH'(s_process_id);
                    cnt_next        = '0;
                    pend_next       = 1'b0;
                    nfree_next      = '0;
                    owned_next      = 1'b0;
                    seen_next       = '0;
                    found_next      = 1'b0;
                    res_status_next = STAT_OK;
                    res_frame_next  = '0;
                    res_offset_next = '0;
                end
            end
            S_SCAN, S_ALLOC: begin
                pend_next = issue;
                if (issue) begin
                    cnt_next   = cnt_reg + 1'b1;
                    idx_d_next = cnt_reg[AW-1:0];
                end
                if (state_reg == S_ALLOC) begin
                    if (pend_reg && !ent_valid && need_reg != '0) begin
                        need_next = need_reg - 1'b1;
                    end
                end else if (pend_reg) begin
                    unique case (op_reg)
                        OP_NEW: begin
                            if (!ent_valid) begin
                                nfree_next = nfree_reg + 1'b1;
                            end else if (ent_match) begin
                                owned_next = 1'b1;
                            end
                        end
                        OP_REF: begin
                            if (ent_match && !found_reg) begin
                                if (div_res.quot == AMT_W'(seen_reg)) begin
                                    found_next = 1'b1;
                                    fidx_next  = idx_d_reg;
                                end else begin
                                    seen_next = seen_reg + 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (scan_end) begin
                    unique case (op_reg)
                        OP_NEW: begin
                            if (owned_reg) begin
                                res_status_next = STAT_ACTIVE;
                            end else if (div_res.quot >= AMT_W'(nfree_reg)) begin
                                res_status_next = STAT_NOFREE;
                            end else begin
                                need_next = CW'(div_res.quot) + 1'b1;
                                cnt_next  = '0;
                                pend_next = 1'b0;
                            end
                        end
                        OP_REF: begin
                            if (found_reg) begin
                                res_frame_next  = FRAME_W'(fidx_reg);
                                res_offset_next = AMT_W'(div_res.rem);
                            end else begin
                                res_status_next = STAT_VIOL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_OUT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_frame_next  = res_frame_reg;
                    out_offset_next = res_offset_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            pb_reg        <= PAGE_UNIT;
            fiu_reg       <= FRAMES_RESET;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            pb_reg        <= pb_next;
            fiu_reg       <= fiu_next;
        end
        op_reg         <= op_next;
        id_reg         <= id_next;
        idx_d_reg      <= idx_d_next;
        nfree_reg      <= nfree_next;
        owned_reg      <= owned_next;
        seen_reg       <= seen_next;
        found_reg      <= found_next;
        fidx_reg       <= fidx_next;
        need_reg       <= need_next;
        res_status_reg <= res_status_next;
        res_frame_reg  <= res_frame_next;
        res_offset_reg <= res_offset_next;
        out_status_reg <= out_status_next;
        out_frame_reg  <= out_frame_next;
        out_offset_reg <= out_offset_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_status = out_status_reg;
    assign m_frame  = out_frame_reg;
    assign m_offset = out_offset_reg;

    a_no_write_on_ref: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && op_reg == OP_REF) |-> !ram_we)
        else $error("owner table written during a reference");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    a_viol_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STAT_VIOL) |-> (m_frame == '0 && m_offset == '0))
        else $error("violation word carries a frame or offset");

    a_alloc_from_new: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ALLOC) |-> (op_reg == OP_NEW && !owned_reg))
        else $error("allocation pass without a grantable new request");

endmodule
